/* sv/permutation_unrank_unit_assert.svh */
// Assertion macros for the permutation unrank unit.
// Depends on nothing; the including module supplies clock and reset.
`ifndef PERMUTATION_UNRANK_UNIT_ASSERT_SVH
`define PERMUTATION_UNRANK_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define PU_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset.
`define PU_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pu_pkg.sv */
// Shared constants, types and the factorial table of the permutation unrank unit.
// No dependencies; the interfaces and modules import this package.
package pu_pkg;

   localparam int unsigned ElementsDefault = 27;
   localparam int unsigned SlotW           = 5;
   localparam int unsigned RankW           = 64;
   localparam int unsigned FactFitMax      = 20;
   localparam int unsigned LaterBits       = 5;
   localparam int unsigned StepW           = 7;

   typedef logic [SlotW-1:0] slot_type;
   typedef logic [RankW-1:0] rank_type;
   typedef logic [StepW-1:0] step_type;

   // full: divide the whole 64-bit dividend; otherwise only its low LaterBits bits
   // produce quotient bits (the quotient is known to be below 32)
   typedef struct packed {
      logic start;
      logic full;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef struct packed {
      logic init;
      logic take;
   } pool_ctl_type;

   // f! for f up to FactFitMax; larger orders return zero
   function automatic rank_type fact_of(input slot_type f);
      rank_type v;
      case (f)
         5'd0:    v = 64'd1;
         5'd1:    v = 64'd1;
         5'd2:    v = 64'd2;
         5'd3:    v = 64'd6;
         5'd4:    v = 64'd24;
         5'd5:    v = 64'd120;
         5'd6:    v = 64'd720;
         5'd7:    v = 64'd5040;
         5'd8:    v = 64'd40320;
         5'd9:    v = 64'd362880;
         5'd10:   v = 64'd3628800;
         5'd11:   v = 64'd39916800;
         5'd12:   v = 64'd479001600;
         5'd13:   v = 64'd6227020800;
         5'd14:   v = 64'd87178291200;
         5'd15:   v = 64'd1307674368000;
         5'd16:   v = 64'd20922789888000;
         5'd17:   v = 64'd355687428096000;
         5'd18:   v = 64'd6402373705728000;
         5'd19:   v = 64'd121645100408832000;
         5'd20:   v = 64'd2432902008176640000;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* sv/pu_ifs.sv */
// Valid/ready channel interfaces for rank transactions in and slot transactions out.
// Depends on pu_pkg.
interface pu_req_if import pu_pkg::*; ();
   logic     valid;
   logic     ready;
   rank_type rank;

   modport source (output valid, output rank, input ready);
   modport sink   (input valid, input rank, output ready);
endinterface

interface pu_rsp_if import pu_pkg::*; ();
   logic     valid;
   logic     ready;
   slot_type position;
   slot_type element;
   logic     last;

   modport source (output valid, output position, output element, output last, input ready);
   modport sink   (input valid, input position, input element, input last, output ready);
endinterface

/* sv/permutation_unrank_unit.sv */
// Permutation unrank unit: 64-bit rank in, ELEMENTS slot transactions out (Lehmer code).
// A slot whose factorial exceeds 64 bits gets digit zero with no division; other slots run
// the shared divider, full width on the first of them. A new rank is taken only in ST_IDLE,
// after the last slot is in the output register; result stalls hold the sequencer in ST_PICK.
// Reset: synchronous, active high; clears the sequencer and output valid.
// Depends on pu_pkg, pu_ifs, pu_div, pu_pool and permutation_unrank_unit_assert.svh.
`include "permutation_unrank_unit_assert.svh"

module permutation_unrank_unit import pu_pkg::*; #(
   parameter int unsigned ELEMENTS = ElementsDefault
) (
   input logic     clock,
   input logic     reset,
   pu_req_if.sink  req_chan,
   pu_rsp_if.source rsp_chan
);

   localparam int unsigned IdxW = $clog2(ELEMENTS);

   // one-hot sequencer
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_PICK  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   slot_type         slot_ff, slot_in;
   rank_type         rem_ff, rem_in;
   logic [IdxW-1:0]  pick_ff, pick_in;
   logic             rsp_valid_ff, rsp_valid_in;
   slot_type         position_ff, position_in;
   slot_type         element_ff, element_in;
   logic             last_ff, last_in;

   slot_type         fact_order;
   logic             fact_fits;
   logic [IdxW-1:0]  last_idx;
   logic             is_last_slot;
   logic             out_free;
   logic             req_take;

   div_ctl_type      div_ctl;
   div_sts_type      div_sts;
   rank_type         div_quo;
   rank_type         div_rem;
   pool_ctl_type     pool_ctl;
   slot_type         chosen;

   // factorial order for this slot is (unused count - 1)
   assign fact_order   = SlotW'(ELEMENTS - 1) - slot_ff;
   assign fact_fits    = (fact_order <= SlotW'(FactFitMax));
   assign last_idx     = IdxW'(ELEMENTS - 1) - IdxW'(slot_ff);
   assign is_last_slot = (slot_ff == SlotW'(ELEMENTS - 1));
   assign out_free     = ~rsp_valid_ff | rsp_chan.ready;
   assign req_take     = req_chan.valid & req_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      rem_in       = rem_ff;
      pick_in      = pick_ff;
      rsp_valid_in = rsp_valid_ff;
      position_in  = position_ff;
      element_in   = element_ff;
      last_in      = last_ff;
      div_ctl      = '0;
      pool_ctl     = '0;

      // drop the output valid once the transaction is taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rem_in        = req_chan.rank;
               slot_in       = '0;
               pool_ctl.init = 1'b1;
               state_in      = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (fact_fits) begin
               // full-width pass on the first dividing slot; later quotients stay below 32
               div_ctl.start = 1'b1;
               div_ctl.full  = (slot_ff == '0) || (fact_order == SlotW'(FactFitMax));
               state_in      = ST_DIV;
            end else begin
               // factorial beyond 64 bits: digit is zero, rank passes through
               pick_in  = '0;
               state_in = ST_PICK;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               rem_in   = div_rem;
               // clamp a digit past the unused count to the last unused entry
               pick_in  = (div_quo > RankW'(last_idx)) ? last_idx : IdxW'(div_quo);
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // hold until the output register can take the slot
            if (out_free) begin
               pool_ctl.take = 1'b1;
               rsp_valid_in  = 1'b1;
               position_in   = slot_ff;
               element_in    = chosen;
               last_in       = is_last_slot;
               if (is_last_slot) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + SlotW'(1);
                  state_in = ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      pick_ff     <= pick_in;
      position_ff <= position_in;
      element_ff  <= element_in;
      last_ff     <= last_in;
   end

   // shared divider: remaining rank by (unused count - 1)!
   pu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (rem_ff),
      .divisor   (fact_of(fact_order)),
      .sts       (div_sts),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // unused elements in ascending order
   pu_pool #(
      .ELEMENTS (ELEMENTS)
   ) u_pool (
      .clock  (clock),
      .ctl    (pool_ctl),
      .pick   (pick_ff),
      .chosen (chosen)
   );

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.position = position_ff;
   assign rsp_chan.element  = element_ff;
   assign rsp_chan.last     = last_ff;

   // a finished division leaves a remainder below the factorial
   `PU_CHECK(a_div_rem_below, (state_ff == ST_DIV) && div_sts.done, div_rem < fact_of(fact_order), "divider remainder not below divisor")
   // an accepted rank starts at slot zero with the divider idle
   `PU_CHECK_NEXT(a_start_slot, req_take, (state_ff == ST_SETUP) && (slot_ff == '0) && !div_sts.busy, "rank did not start at slot zero")
   // the last flag marks the final slot only
   `PU_CHECK(a_last_slot, rsp_valid_ff, last_ff == (position_ff == SlotW'(ELEMENTS - 1)), "last flag on wrong slot")
   // a pick never points past the unused entries
   `PU_CHECK(a_pick_range, state_ff == ST_PICK, pick_ff <= last_idx, "pick index beyond unused count")

endmodule

/* sv/pu_div.sv */
// Shared restoring divider: one compare-and-subtract per cycle, 64 or 5 steps.
// Depends on pu_pkg.
module pu_div import pu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   input  rank_type    dividend,
   input  rank_type    divisor,
   output div_sts_type sts,
   output rank_type    quotient,
   output rank_type    remainder
);

   rank_type     rem_ff, rem_in;
   rank_type     quo_ff, quo_in;
   rank_type     den_ff, den_in;
   step_type     steps_ff, steps_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [RankW:0] trial;
   logic [RankW:0] diff;
   logic         fits;

   assign trial = {rem_ff, quo_ff[RankW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = ~diff[RankW];

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         den_in  = divisor;
         busy_in = 1'b1;
         if (ctl.full) begin
            rem_in   = '0;
            quo_in   = dividend;
            steps_in = StepW'(RankW);
         end else begin
            rem_in   = dividend >> LaterBits;
            quo_in   = dividend << (RankW - LaterBits);
            steps_in = StepW'(LaterBits);
         end
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in   = fits ? diff[RankW-1:0] : trial[RankW-1:0];
         quo_in   = {quo_ff[RankW-2:0], fits};
         steps_in = steps_ff - StepW'(1);
         if (steps_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      steps_ff <= steps_in;
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* sv/pu_pool.sv */
// Ordered list of still-unused elements with pick-and-remove.
// Depends on pu_pkg.
module pu_pool import pu_pkg::*; #(
   parameter int unsigned ELEMENTS = ElementsDefault
) (
   input  logic                        clock,
   input  pool_ctl_type                ctl,
   input  logic [$clog2(ELEMENTS)-1:0] pick,
   output slot_type                    chosen
);

   localparam int unsigned IdxW = $clog2(ELEMENTS);

   slot_type list_ff [ELEMENTS];
   slot_type list_in [ELEMENTS];

   assign chosen = list_ff[pick];

   always_comb begin
      for (int i = 0; i < ELEMENTS; i++) begin
         list_in[i] = list_ff[i];
         if (ctl.init) begin
            list_in[i] = SlotW'(i);
         end else if (ctl.take && (i < ELEMENTS - 1) && (IdxW'(i) >= pick)) begin
            // close the gap left by the picked entry
            list_in[i] = list_ff[(i < ELEMENTS - 1) ? i + 1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ELEMENTS; i++) begin
         list_ff[i] <= list_in[i];
      end
   end

endmodule
